FILE: rtl/tag_stack_with_topmost_search_assert.svh
`ifndef TAG_STACK_WITH_TOPMOST_SEARCH_ASSERT_SVH
`define TAG_STACK_WITH_TOPMOST_SEARCH_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define TSTS_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define TSTS_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/tsts_pkg.sv
package tsts_pkg;

	localparam int TSTS_STACK_DEPTH = 64;
	localparam int TSTS_TAG_BITS    = 8;

	typedef enum logic [2:0] {
		OP_PUSH   = 3'd0,
		OP_POP    = 3'd1,
		OP_READ   = 3'd2,
		OP_FIND   = 3'd3,
		OP_CLEAR  = 3'd4,
		OP_TOP    = 3'd5,
		OP_BOTTOM = 3'd6
	} tsts_op_t;

	typedef struct packed {
		tsts_op_t   op;
		logic [7:0] tag;
		logic [5:0] index;
	} tsts_cmd_t;

	typedef struct packed {
		logic [7:0] tag_out;
		logic [5:0] position;
		logic       found;
		logic [6:0] fill_count;
		logic       overflow;
	} tsts_rsp_t;

endpackage

FILE: rtl/tag_stack_with_topmost_search.sv
// Push, clear, unused codes and misses (empty stack, index past the fill): result registered
// at the accept edge, next request taken in the following cycle.
// Pop, top, bottom and hitting reads: one RAM read, then the result registered from ST_READ.
// Find: walks down from the top one entry a cycle on the RAM read port.
// A result waiting on rsp_stall holds the next result in a spare register, then stalls requests.
// Reset clears the fill count and handshake state at once; the tag RAM is not cleared.
module tag_stack_with_topmost_search
	import tsts_pkg::*;
#(
	parameter int STACK_DEPTH = TSTS_STACK_DEPTH,
	parameter int TAG_BITS    = TSTS_TAG_BITS
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_stall,
	input  tsts_cmd_t cmd,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output tsts_rsp_t rsp
);

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int NB = (TAG_BITS < 8) ? TAG_BITS : 8;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_READ = 4'b0010,
		ST_SCAN = 4'b0100,
		ST_EMIT = 4'b1000
	} tsts_state_t;

	tsts_state_t         state_q, state_d;
	logic [CW-1:0]       count_q, count_d;
	logic [AW-1:0]       k_q, k_d;
	logic [TAG_BITS-1:0] key_q, key_d;
	tsts_rsp_t           hold_q, res_d;
	logic                rsp_valid_q;
	tsts_rsp_t           rsp_q;

	logic                accept, fin, out_free;
	logic                we, re;
	logic [AW-1:0]       raddr, top_addr;
	logic [TAG_BITS-1:0] tag_m, rd_data;
	logic [7:0]          rd_tag8;
	logic                idx_hit;

	tsts_ram #(
		.WIDTH (TAG_BITS),
		.DEPTH (STACK_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (AW'(count_q)),
		.wdata (tag_m),
		.re    (re),
		.raddr (raddr),
		.rdata (rd_data)
	);

	assign tag_m    = TAG_BITS'(cmd.tag[NB-1:0]);
	assign rd_tag8  = 8'(rd_data[NB-1:0]);
	assign top_addr = AW'(count_q - CW'(1));
	assign idx_hit  = 32'(cmd.index) < 32'(count_q);

	assign cmd_stall = (state_q != ST_IDLE);
	assign accept    = cmd_valid && !cmd_stall;
	assign out_free  = !rsp_valid_q || !rsp_stall;

	always_comb begin
		state_d = state_q;
		count_d = count_q;
		k_d     = k_q;
		key_d   = key_q;
		we      = 1'b0;
		re      = 1'b0;
		raddr   = '0;
		fin     = 1'b0;
		res_d   = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (cmd.op)
						OP_PUSH: begin
							fin = 1'b1;
							if (count_q != CW'(STACK_DEPTH)) begin
								we      = 1'b1;
								count_d = count_q + CW'(1);
							end else begin
								res_d.overflow = 1'b1;
							end
						end
						OP_POP: begin
							if (count_q != '0) begin
								re      = 1'b1;
								raddr   = top_addr;
								count_d = count_q - CW'(1);
								state_d = ST_READ;
							end else begin
								fin = 1'b1;
							end
						end
						OP_READ: begin
							if (idx_hit) begin
								re      = 1'b1;
								raddr   = AW'(cmd.index);
								state_d = ST_READ;
							end else begin
								fin = 1'b1;
							end
						end
						OP_FIND: begin
							if (count_q != '0) begin
								re      = 1'b1;
								raddr   = top_addr;
								k_d     = top_addr;
								key_d   = tag_m;
								state_d = ST_SCAN;
							end else begin
								fin = 1'b1;
							end
						end
						OP_CLEAR: begin
							count_d = '0;
							fin     = 1'b1;
						end
						OP_TOP: begin
							if (count_q != '0) begin
								re      = 1'b1;
								raddr   = top_addr;
								state_d = ST_READ;
							end else begin
								fin = 1'b1;
							end
						end
						OP_BOTTOM: begin
							if (count_q != '0) begin
								re      = 1'b1;
								state_d = ST_READ;
							end else begin
								fin = 1'b1;
							end
						end
						default: begin
							fin = 1'b1;
						end
					endcase
				end
			end
			ST_READ: begin
				fin           = 1'b1;
				res_d.found   = 1'b1;
				res_d.tag_out = rd_tag8;
			end
			ST_SCAN: begin
				if (rd_data == key_q) begin
					fin            = 1'b1;
					res_d.found    = 1'b1;
					res_d.tag_out  = rd_tag8;
					res_d.position = 6'(k_q);
				end else if (k_q == '0) begin
					fin = 1'b1;
				end else begin
					re    = 1'b1;
					raddr = k_q - AW'(1);
					k_d   = k_q - AW'(1);
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		res_d.fill_count = 7'(count_d);
		if (fin) begin
			state_d = out_free ? ST_IDLE : ST_EMIT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if ((fin || state_q == ST_EMIT) && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		k_q   <= k_d;
		key_q <= key_d;
		if (fin && !out_free) begin
			hold_q <= res_d;
		end
		if (out_free) begin
			if (state_q == ST_EMIT) begin
				rsp_q <= hold_q;
			end else if (fin) begin
				rsp_q <= res_d;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

FILE: rtl/tsts_ram.sv
module tsts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/tsts_checker.sv
`include "tag_stack_with_topmost_search_assert.svh"

module tsts_checker
	import tsts_pkg::*;
#(
	parameter int STACK_DEPTH = TSTS_STACK_DEPTH
) (
	input logic      clk,
	input logic      arst_n,
	input logic      cmd_valid,
	input logic      cmd_stall,
	input tsts_cmd_t cmd,
	input logic      rsp_valid,
	input logic      rsp_stall,
	input tsts_rsp_t rsp
);

	`TSTS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "stalled response changed")
	`TSTS_ASSERT_NOW(a_ovf_full, rsp_valid && rsp.overflow, rsp.fill_count == 7'(STACK_DEPTH) && !rsp.found, "overflow below full")
	`TSTS_ASSERT_NOW(a_miss_zero, rsp_valid && !rsp.found, rsp.tag_out == 8'd0 && rsp.position == 6'd0, "miss with nonzero data")
	`TSTS_ASSERT_NEXT(a_wait_stalls, cmd_valid && !cmd_stall && rsp_valid && rsp_stall, cmd_stall, "request taken past a waiting response")
	`TSTS_ASSERT_NEXT(a_quick_ops, cmd_valid && !cmd_stall && (cmd.op == OP_PUSH || cmd.op == OP_CLEAR) && !(rsp_valid && rsp_stall), !cmd_stall, "push or clear held the input")

endmodule

bind tag_stack_with_topmost_search tsts_checker #(.STACK_DEPTH(STACK_DEPTH)) u_tsts_checker (.*);
